FILE: hdl/cbmq_pkg.sv
package cbmq_pkg;

    // opcodes
    localparam logic [2:0] OP_CLEAR     = 3'd0;
    localparam logic [2:0] OP_INSERT    = 3'd1;
    localparam logic [2:0] OP_GET_NEXT  = 3'd2;
    localparam logic [2:0] OP_HAS_FIELD = 3'd3;
    localparam logic [2:0] OP_FIND      = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_NONE = 2'd3;

    // side-move group filter codes
    localparam logic [1:0] GRP_SINGLE = 2'd0;
    localparam logic [1:0] GRP_PAIR   = 2'd1;
    localparam logic [1:0] GRP_TRIPLE = 2'd2;
    localparam logic [1:0] GRP_ALL    = 2'd3;

    localparam logic [2:0] DIR_NONE = 3'd0;

    // configuration register indexes
    localparam int         CFG_IDX_W    = 3;
    localparam logic [2:0] CFG_NONE     = 3'd0;
    localparam logic [2:0] CFG_S3_LEFT  = 3'd1;
    localparam logic [2:0] CFG_S3_RIGHT = 3'd2;
    localparam logic [2:0] CFG_S2_LEFT  = 3'd3;
    localparam logic [2:0] CFG_S2_RIGHT = 3'd4;

    localparam logic [3:0] RST_NONE     = 4'd13;
    localparam logic [3:0] RST_S3_LEFT  = 4'd7;
    localparam logic [3:0] RST_S3_RIGHT = 4'd8;
    localparam logic [3:0] RST_S2_LEFT  = 4'd9;
    localparam logic [3:0] RST_S2_RIGHT = 4'd10;

    localparam int REC_W = 14;

    typedef struct packed {
        logic [6:0] fld;
        logic [2:0] dir;
        logic [3:0] cls;
    } t_rec;

    typedef struct packed {
        logic [3:0] none_code;
        logic [3:0] s3_left;
        logic [3:0] s3_right;
        logic [3:0] s2_left;
        logic [3:0] s2_right;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_LINK,
        S_GN_STEP,
        S_GN_READ,
        S_SCAN
    } t_state;

endpackage

FILE: hdl/cbmq_ram.sv
module cbmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/cbmq_match.sv
module cbmq_match (
    input  cbmq_pkg::t_rec i_rec,
    input  logic [2:0]     i_op,
    input  logic [6:0]     i_fld,
    input  logic [2:0]     i_dir,
    input  logic [3:0]     i_cls,
    input  logic [1:0]     i_grp,
    input  cbmq_pkg::t_cfg i_cfg,
    output logic           o_hit
);

    logic       fld_eq;
    logic       dir_ok;
    logic       cls_ok;
    logic       grp_ok;
    logic [1:0] want;

    always_comb begin
        // three-stone codes win when they overlap two-stone codes
        if (i_rec.cls == i_cfg.s3_left || i_rec.cls == i_cfg.s3_right) begin
            want = cbmq_pkg::GRP_TRIPLE;
        end else if (i_rec.cls == i_cfg.s2_left || i_rec.cls == i_cfg.s2_right) begin
            want = cbmq_pkg::GRP_PAIR;
        end else begin
            want = cbmq_pkg::GRP_SINGLE;
        end
    end

    assign fld_eq = (i_rec.fld == i_fld);
    assign dir_ok = (i_dir == cbmq_pkg::DIR_NONE) || (i_rec.dir == i_dir);
    assign cls_ok = (i_cls == i_cfg.none_code) || (i_cls == i_rec.cls);
    assign grp_ok = (i_cls == i_rec.cls) || (i_grp == want) || (i_grp == cbmq_pkg::GRP_ALL);

    assign o_hit = (i_op == cbmq_pkg::OP_FIND) ? (fld_eq && dir_ok && cls_ok && grp_ok)
                                               : fld_eq;

endmodule

FILE: hdl/class_bucketed_move_queue.sv
// channel   direction  ports                                             handshake
// command   in         i_opcode i_move_field i_move_direction            i_start, o_busy
//                      i_move_type i_group_filter i_max_type
// result    out        o_status o_found o_out_field o_out_direction      o_done strobe
//                      o_out_type
// config    in         i_cfg_index i_cfg_data                            i_cfg_we
//
// clear, unused opcodes and dropped inserts end in dispatch; insert goes on to S_INS_LINK
// has field / find: S_SCAN reads slots up to the fill count, one slot read per cycle,
// and stops at the first hit; get next: S_GN_STEP enters classes until a record is
// read out in S_GN_READ or the get is refused, also when the cursor is past the last class
// reset clears class valid bits, fill count and cursor; no memory clearing pass
// o_busy drops in the cycle the result shows, so the next item can be taken then
// results are shown for one cycle only; the receiver cannot stall them
module class_bucketed_move_queue #(
    parameter int CAPACITY  = 256,
    parameter int NUM_TYPES = 13
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [2:0]                     i_opcode,
    input  logic [6:0]                     i_move_field,
    input  logic [2:0]                     i_move_direction,
    input  logic [3:0]                     i_move_type,
    input  logic [1:0]                     i_group_filter,
    input  logic [3:0]                     i_max_type,
    input  logic                           i_cfg_we,
    input  logic [cbmq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [3:0]                     i_cfg_data,
    output logic                           o_done,
    output logic [1:0]                     o_status,
    output logic                           o_found,
    output logic [6:0]                     o_out_field,
    output logic [2:0]                     o_out_direction,
    output logic [3:0]                     o_out_type
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int FW  = $clog2(CAPACITY + 1);
    localparam int TW  = $clog2(NUM_TYPES);
    localparam int CPW = $clog2(NUM_TYPES + 2);
    localparam int LW  = AW + 1;
    localparam logic [FW-1:0]  CAP_C = FW'(CAPACITY);
    localparam logic [CPW-1:0] NT_C  = CPW'(NUM_TYPES);

    cbmq_pkg::t_state r_state, n_state;
    cbmq_pkg::t_cfg   r_cfg;

    logic [2:0] r_op;
    logic [6:0] r_fld;
    logic [2:0] r_dir;
    logic [3:0] r_typ;
    logic [1:0] r_grp;
    logic [3:0] r_maxt;

    logic [FW-1:0]  r_fill, n_fill;
    logic [CPW-1:0] r_cpos, n_cpos;   // cursor class plus one, zero is before the first class
    logic [FW-1:0]  r_addr, n_addr;
    logic           r_pend, n_pend;

    logic           r_done, n_done;
    logic [1:0]     r_status, n_status;
    logic           r_found, n_found;
    logic [6:0]     r_of, n_of;
    logic [2:0]     r_od, n_od;
    logic [3:0]     r_ot, n_ot;

    logic [NUM_TYPES-1:0] r_head_v;
    logic [NUM_TYPES-1:0] r_cur_v;
    logic [AW-1:0]        r_head [NUM_TYPES];
    logic [AW-1:0]        r_tail [NUM_TYPES];
    logic [AW-1:0]        r_cur  [NUM_TYPES];

    logic          accept;
    logic          clr, ins_commit, gn_load, gn_adv;
    logic          store_we, link_we;
    logic [AW-1:0] link_waddr;
    logic [LW-1:0] link_wdata;
    logic [AW-1:0] rd_addr;
    logic [cbmq_pkg::REC_W-1:0] store_rdata;
    logic [LW-1:0] link_rdata;
    cbmq_pkg::t_rec rec;
    logic          hit;

    logic [TW-1:0]  typ_idx;
    logic [CPW-1:0] cpos_m1;
    logic [TW-1:0]  cur_idx;
    logic [TW-1:0]  load_idx;

    assign accept   = i_start && !o_busy;
    assign typ_idx  = r_typ[TW-1:0];
    assign cpos_m1  = r_cpos - 1'b1;
    assign cur_idx  = cpos_m1[TW-1:0];
    assign load_idx = r_cpos[TW-1:0];
    assign rec      = cbmq_pkg::t_rec'(store_rdata);

    cbmq_ram #(
        .WIDTH(cbmq_pkg::REC_W),
        .DEPTH(CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata ({r_fld, r_dir, r_typ}),
        .i_raddr (rd_addr),
        .o_rdata (store_rdata)
    );

    cbmq_ram #(
        .WIDTH(LW),
        .DEPTH(CAPACITY)
    ) u_link (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (rd_addr),
        .o_rdata (link_rdata)
    );

    cbmq_match u_match (
        .i_rec (rec),
        .i_op  (r_op),
        .i_fld (r_fld),
        .i_dir (r_dir),
        .i_cls (r_typ),
        .i_grp (r_grp),
        .i_cfg (r_cfg),
        .o_hit (hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{none_code: cbmq_pkg::RST_NONE,
                       s3_left:   cbmq_pkg::RST_S3_LEFT,
                       s3_right:  cbmq_pkg::RST_S3_RIGHT,
                       s2_left:   cbmq_pkg::RST_S2_LEFT,
                       s2_right:  cbmq_pkg::RST_S2_RIGHT};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cbmq_pkg::CFG_NONE:     r_cfg.none_code <= i_cfg_data;
                cbmq_pkg::CFG_S3_LEFT:  r_cfg.s3_left   <= i_cfg_data;
                cbmq_pkg::CFG_S3_RIGHT: r_cfg.s3_right  <= i_cfg_data;
                cbmq_pkg::CFG_S2_LEFT:  r_cfg.s2_left   <= i_cfg_data;
                cbmq_pkg::CFG_S2_RIGHT: r_cfg.s2_right  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_opcode;
            r_fld  <= i_move_field;
            r_dir  <= i_move_direction;
            r_typ  <= i_move_type;
            r_grp  <= i_group_filter;
            r_maxt <= i_max_type;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbmq_pkg::S_IDLE;
            r_fill  <= '0;
            r_cpos  <= '0;
            r_addr  <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_cpos  <= n_cpos;
            r_addr  <= n_addr;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_found  <= n_found;
        r_of     <= n_of;
        r_od     <= n_od;
        r_ot     <= n_ot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_v <= '0;
            r_cur_v  <= '0;
        end else if (clr) begin
            r_head_v <= '0;
            r_cur_v  <= '0;
        end else begin
            if (ins_commit) begin
                r_head_v[typ_idx] <= 1'b1;
            end
            if (gn_load) begin
                r_cur_v[load_idx] <= r_head_v[load_idx];
            end
            if (gn_adv) begin
                r_cur_v[cur_idx] <= link_rdata[AW];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ins_commit) begin
            if (!r_head_v[typ_idx]) begin
                r_head[typ_idx] <= r_fill[AW-1:0];
            end
            r_tail[typ_idx] <= r_fill[AW-1:0];
        end
        if (gn_load) begin
            r_cur[load_idx] <= r_head[load_idx];
        end
        if (gn_adv) begin
            r_cur[cur_idx] <= link_rdata[AW-1:0];
        end
    end

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_cpos     = r_cpos;
        n_addr     = r_addr;
        n_pend     = 1'b0;
        n_done     = 1'b0;
        n_status   = cbmq_pkg::ST_OK;
        n_found    = 1'b0;
        n_of       = '0;
        n_od       = '0;
        n_ot       = '0;
        clr        = 1'b0;
        ins_commit = 1'b0;
        gn_load    = 1'b0;
        gn_adv     = 1'b0;
        store_we   = 1'b0;
        link_we    = 1'b0;
        link_waddr = r_fill[AW-1:0];
        link_wdata = '0;
        rd_addr    = r_addr[AW-1:0];

        case (r_state)
            cbmq_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = cbmq_pkg::S_DISPATCH;
                end
            end
            cbmq_pkg::S_DISPATCH: begin
                case (r_op)
                    cbmq_pkg::OP_CLEAR: begin
                        clr     = 1'b1;
                        n_fill  = '0;
                        n_cpos  = '0;
                        n_done  = 1'b1;
                        n_state = cbmq_pkg::S_IDLE;
                    end
                    cbmq_pkg::OP_INSERT: begin
                        if (r_typ >= 4'(NUM_TYPES)) begin
                            n_status = cbmq_pkg::ST_BAD;
                            n_done   = 1'b1;
                            n_state  = cbmq_pkg::S_IDLE;
                        end else if (r_fill >= CAP_C) begin
                            n_status = cbmq_pkg::ST_FULL;
                            n_done   = 1'b1;
                            n_state  = cbmq_pkg::S_IDLE;
                        end else begin
                            store_we = 1'b1;
                            // chain the old tail to the new slot
                            if (r_head_v[typ_idx]) begin
                                link_we    = 1'b1;
                                link_waddr = r_tail[typ_idx];
                                link_wdata = {1'b1, r_fill[AW-1:0]};
                            end
                            n_state = cbmq_pkg::S_INS_LINK;
                        end
                    end
                    cbmq_pkg::OP_GET_NEXT: begin
                        n_state = cbmq_pkg::S_GN_STEP;
                    end
                    cbmq_pkg::OP_HAS_FIELD, cbmq_pkg::OP_FIND: begin
                        n_addr  = '0;
                        n_state = cbmq_pkg::S_SCAN;
                    end
                    default: begin
                        n_done  = 1'b1;
                        n_state = cbmq_pkg::S_IDLE;
                    end
                endcase
            end
            cbmq_pkg::S_INS_LINK: begin
                // new slot is the end of its chain
                link_we    = 1'b1;
                link_waddr = r_fill[AW-1:0];
                link_wdata = '0;
                ins_commit = 1'b1;
                n_fill     = r_fill + 1'b1;
                n_done     = 1'b1;
                n_state    = cbmq_pkg::S_IDLE;
            end
            cbmq_pkg::S_GN_STEP: begin
                if (r_cpos > NT_C) begin
                    n_status = cbmq_pkg::ST_NONE;
                    n_done   = 1'b1;
                    n_state  = cbmq_pkg::S_IDLE;
                end else if (r_cpos != '0 && r_cur_v[cur_idx]) begin
                    rd_addr = r_cur[cur_idx];
                    n_state = cbmq_pkg::S_GN_READ;
                end else begin
                    // enter the next class
                    n_cpos = r_cpos + 1'b1;
                    if (r_cpos >= NT_C) begin
                        n_status = cbmq_pkg::ST_NONE;
                        n_done   = 1'b1;
                        n_state  = cbmq_pkg::S_IDLE;
                    end else begin
                        gn_load = 1'b1;
                        if (int'(r_cpos) > int'(r_maxt)) begin
                            n_status = cbmq_pkg::ST_NONE;
                            n_done   = 1'b1;
                            n_state  = cbmq_pkg::S_IDLE;
                        end
                    end
                end
            end
            cbmq_pkg::S_GN_READ: begin
                gn_adv  = 1'b1;
                n_found = 1'b1;
                n_of    = rec.fld;
                n_od    = rec.dir;
                n_ot    = rec.cls;
                n_done  = 1'b1;
                n_state = cbmq_pkg::S_IDLE;
            end
            cbmq_pkg::S_SCAN: begin
                if (r_pend && hit) begin
                    n_found = 1'b1;
                    n_of    = r_fld;
                    if (r_op == cbmq_pkg::OP_FIND) begin
                        n_od = rec.dir;
                        n_ot = rec.cls;
                    end
                    n_done  = 1'b1;
                    n_state = cbmq_pkg::S_IDLE;
                end else if (r_addr < r_fill) begin
                    // one slot per cycle, checked when its data returns
                    rd_addr = r_addr[AW-1:0];
                    n_addr  = r_addr + 1'b1;
                    n_pend  = 1'b1;
                end else begin
                    n_status = cbmq_pkg::ST_NONE;
                    n_done   = 1'b1;
                    n_state  = cbmq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cbmq_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy          = (r_state != cbmq_pkg::S_IDLE);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_found         = r_found;
    assign o_out_field     = r_of;
    assign o_out_direction = r_od;
    assign o_out_type      = r_ot;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CAP_C)
        else $error("fill count above capacity");

    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cpos <= NT_C + 1'b1)
        else $error("class cursor past the end");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && r_found |-> r_status == cbmq_pkg::ST_OK)
        else $error("found item with a failing status");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_busy && !o_done)
        else $error("accepted item did not make the block busy");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ins_commit |=> r_fill == $past(r_fill) + 1'b1)
        else $error("insert did not advance the fill count");

endmodule

FILE: tb/tb_class_bucketed_move_queue.sv
module tb_class_bucketed_move_queue;

    localparam int CAP       = 256;
    localparam int NTYPES    = 13;
    localparam int LIMIT     = 2_000_000;
    localparam int SEG_ITEMS = 150;

    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic [6:0] fld;
        logic [2:0] dir;
        logic [3:0] cls;
        logic [1:0] grp;
        logic [3:0] maxc;
    } t_cmd;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [6:0] fld;
        logic [2:0] dir;
        logic [3:0] cls;
    } t_res;

    typedef struct packed {
        t_cmd c;
        logic chk;
        t_res r;
    } t_row;

    logic       i_clk            = 1'b0;
    logic       i_rst_n          = 1'b0;
    logic       i_start          = 1'b0;
    logic [2:0] i_opcode         = cbmq_pkg::OP_CLEAR;
    logic [6:0] i_move_field     = 7'd0;
    logic [2:0] i_move_direction = cbmq_pkg::DIR_NONE;
    logic [3:0] i_move_type      = 4'd0;
    logic [1:0] i_group_filter   = cbmq_pkg::GRP_SINGLE;
    logic [3:0] i_max_type       = 4'd0;
    logic       i_cfg_we         = 1'b0;
    logic [cbmq_pkg::CFG_IDX_W-1:0] i_cfg_index = cbmq_pkg::CFG_NONE;
    logic [3:0] i_cfg_data       = 4'd0;
    logic       o_busy;
    logic       o_done;
    logic [1:0] o_status;
    logic       o_found;
    logic [6:0] o_out_field;
    logic [2:0] o_out_direction;
    logic [3:0] o_out_type;

    class_bucketed_move_queue #(
        .CAPACITY  (CAP),
        .NUM_TYPES (NTYPES)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_opcode        (i_opcode),
        .i_move_field    (i_move_field),
        .i_move_direction(i_move_direction),
        .i_move_type     (i_move_type),
        .i_group_filter  (i_group_filter),
        .i_max_type      (i_max_type),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_found         (o_found),
        .o_out_field     (o_out_field),
        .o_out_direction (o_out_direction),
        .o_out_type      (o_out_type)
    );

    always #10 i_clk = ~i_clk;

    // shadow copy of the queue state
    cbmq_pkg::t_rec slot_rec     [CAP];
    int             slot_link    [CAP];
    bit             slot_link_ok [CAP];
    int             chain_head   [NTYPES];
    bit             chain_head_ok[NTYPES];
    int             chain_tail   [NTYPES];
    int             walk_pos     [NTYPES];
    bit             walk_pos_ok  [NTYPES];
    int             fill_cnt;
    int             walk_cls;
    cbmq_pkg::t_cfg cfg;

    t_res pending_results[$];
    t_res oldest_result;
    int   mismatches  = 0;
    int   items_sent  = 0;
    int   idle_pct    = 15;
    int   cycles      = 0;

    function automatic void clear_queue();
        for (int t = 0; t < NTYPES; t++) begin
            chain_head_ok[t] = 1'b0;
            walk_pos_ok[t]   = 1'b0;
        end
        fill_cnt = 0;
        walk_cls = -1;
    endfunction

    function automatic t_res apply_queue_op(t_cmd c);
        t_res           r;
        bit             ok;
        bit             hit;
        int             s;
        int             k;
        cbmq_pkg::t_rec rec;
        logic [1:0]     want;
        r = '0;
        k = int'(c.cls);
        case (c.op)
            cbmq_pkg::OP_CLEAR: clear_queue();
            cbmq_pkg::OP_INSERT: begin
                if (k >= NTYPES) begin
                    r.status = cbmq_pkg::ST_BAD;
                end else if (fill_cnt >= CAP) begin
                    r.status = cbmq_pkg::ST_FULL;
                end else begin
                    s = fill_cnt;
                    if (!chain_head_ok[k]) begin
                        chain_head[k]    = s;
                        chain_head_ok[k] = 1'b1;
                    end else begin
                        slot_link[chain_tail[k]]    = s;
                        slot_link_ok[chain_tail[k]] = 1'b1;
                    end
                    chain_tail[k]   = s;
                    slot_link_ok[s] = 1'b0;
                    slot_rec[s]     = '{fld: c.fld, dir: c.dir, cls: c.cls};
                    fill_cnt        = s + 1;
                end
            end
            cbmq_pkg::OP_GET_NEXT: begin
                ok = (walk_cls < NTYPES);
                // the cursor keeps moving into the next class even when it refuses
                while (ok && (walk_cls < 0 || !walk_pos_ok[walk_cls])) begin
                    walk_cls++;
                    if (walk_cls >= NTYPES) begin
                        ok = 1'b0;
                        break;
                    end
                    walk_pos[walk_cls]    = chain_head[walk_cls];
                    walk_pos_ok[walk_cls] = chain_head_ok[walk_cls];
                    if (walk_cls > int'(c.maxc)) begin
                        ok = 1'b0;
                        break;
                    end
                end
                if (ok) begin
                    s = walk_pos[walk_cls];
                    r.found = 1'b1;
                    r.fld   = slot_rec[s].fld;
                    r.dir   = slot_rec[s].dir;
                    r.cls   = slot_rec[s].cls;
                    walk_pos[walk_cls]    = slot_link[s];
                    walk_pos_ok[walk_cls] = slot_link_ok[s];
                end else begin
                    r.status = cbmq_pkg::ST_NONE;
                end
            end
            cbmq_pkg::OP_HAS_FIELD: begin
                r.status = cbmq_pkg::ST_NONE;
                for (int i = 0; i < fill_cnt; i++) begin
                    if (slot_rec[i].fld == c.fld) begin
                        r.status = cbmq_pkg::ST_OK;
                        r.found  = 1'b1;
                        r.fld    = c.fld;
                        break;
                    end
                end
            end
            cbmq_pkg::OP_FIND: begin
                r.status = cbmq_pkg::ST_NONE;
                for (int i = 0; i < fill_cnt; i++) begin
                    rec = slot_rec[i];
                    if (rec.fld != c.fld) continue;
                    if (c.dir != cbmq_pkg::DIR_NONE && rec.dir != c.dir) continue;
                    if (c.cls != cfg.none_code && c.cls != rec.cls) continue;
                    if (c.cls == rec.cls) begin
                        hit = 1'b1;
                    end else begin
                        // three-stone codes win over two-stone codes
                        if (rec.cls == cfg.s3_left || rec.cls == cfg.s3_right)
                            want = cbmq_pkg::GRP_TRIPLE;
                        else if (rec.cls == cfg.s2_left || rec.cls == cfg.s2_right)
                            want = cbmq_pkg::GRP_PAIR;
                        else
                            want = cbmq_pkg::GRP_SINGLE;
                        hit = (c.grp == want || c.grp == cbmq_pkg::GRP_ALL);
                    end
                    if (hit) begin
                        r.status = cbmq_pkg::ST_OK;
                        r.found  = 1'b1;
                        r.fld    = c.fld;
                        r.dir    = rec.dir;
                        r.cls    = rec.cls;
                        break;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("mismatch %s: got %0d expected %0d, cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no item pending", 8'(o_status), 8'd0);
            end else begin
                oldest_result = pending_results.pop_front();
                if (o_status !== oldest_result.status)
                    report_mismatch("status", 8'(o_status), 8'(oldest_result.status));
                if (o_found !== oldest_result.found)
                    report_mismatch("found", 8'(o_found), 8'(oldest_result.found));
                if (o_out_field !== oldest_result.fld)
                    report_mismatch("field", 8'(o_out_field), 8'(oldest_result.fld));
                if (o_out_direction !== oldest_result.dir)
                    report_mismatch("direction", 8'(o_out_direction), 8'(oldest_result.dir));
                if (o_out_type !== oldest_result.cls)
                    report_mismatch("class", 8'(o_out_type), 8'(oldest_result.cls));
            end
        end
    end

    // called at a rising edge; returns at the edge where the item was taken
    task automatic issue(t_cmd c, bit typed = 1'b0, t_res typed_r = '0);
        int   gap;
        t_res r;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start          <= 1'b1;
        i_opcode         <= c.op;
        i_move_field     <= c.fld;
        i_move_direction <= c.dir;
        i_move_type      <= c.cls;
        i_group_filter   <= c.grp;
        i_max_type       <= c.maxc;
        do @(posedge i_clk); while (o_busy);
        r = apply_queue_op(c);
        pending_results.push_back(typed ? typed_r : r);
        if (c.op <= cbmq_pkg::OP_FIND) items_sent++;
    endtask

    task automatic pause_until_drained();
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_reg(logic [cbmq_pkg::CFG_IDX_W-1:0] idx, logic [3:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    task automatic configure(cbmq_pkg::t_cfg c);
        write_reg(cbmq_pkg::CFG_NONE, c.none_code);
        write_reg(cbmq_pkg::CFG_S3_LEFT, c.s3_left);
        write_reg(cbmq_pkg::CFG_S3_RIGHT, c.s3_right);
        write_reg(cbmq_pkg::CFG_S2_LEFT, c.s2_left);
        write_reg(cbmq_pkg::CFG_S2_RIGHT, c.s2_right);
        i_cfg_we <= 1'b0;
        cfg = c;
    endtask

    function automatic cbmq_pkg::t_cfg settings_for(int seg);
        case (seg)
            0: return '{4'd0, 4'd0, 4'd15, 4'd15, 4'd0};
            1: return '{4'($urandom_range(15)), 4'($urandom_range(15)),
                        4'($urandom_range(15)), 4'($urandom_range(15)),
                        4'($urandom_range(15))};
            2: return '{4'd15, 4'd3, 4'd3, 4'd3, 4'd12};
            3: return '{4'($urandom_range(NTYPES - 1)), 4'($urandom_range(NTYPES - 1)),
                        4'($urandom_range(NTYPES - 1)), 4'($urandom_range(NTYPES - 1)),
                        4'($urandom_range(NTYPES - 1))};
            4: return '{4'd15, 4'd15, 4'd15, 4'd15, 4'd15};
            default: return '{cbmq_pkg::RST_NONE, cbmq_pkg::RST_S3_LEFT,
                              cbmq_pkg::RST_S3_RIGHT, cbmq_pkg::RST_S2_LEFT,
                              cbmq_pkg::RST_S2_RIGHT};
        endcase
    endfunction

    function automatic t_cmd rand_cmd(logic [2:0] op, logic [6:0] base, bit narrow);
        t_cmd c;
        c.op  = op;
        c.fld = narrow ? base + 7'($urandom_range(7)) : 7'($urandom_range(127));
        c.dir = (op == cbmq_pkg::OP_FIND && $urandom_range(1) == 0) ? cbmq_pkg::DIR_NONE
                                                                    : 3'($urandom_range(6));
        if (op == cbmq_pkg::OP_FIND && $urandom_range(9) < 4)
            c.cls = cfg.none_code;
        else if ($urandom_range(99) < 85)
            c.cls = 4'($urandom_range(NTYPES - 1));
        else
            c.cls = 4'($urandom_range(15));
        c.grp  = 2'($urandom_range(3));
        c.maxc = ($urandom_range(9) < 7) ? 4'($urandom_range(NTYPES - 1))
                                         : 4'($urandom_range(15));
        return c;
    endfunction

    function automatic logic [2:0] pick_query_op();
        int r;
        r = $urandom_range(99);
        if (r < 40) return cbmq_pkg::OP_GET_NEXT;
        if (r < 70) return cbmq_pkg::OP_FIND;
        if (r < 85) return cbmq_pkg::OP_HAS_FIELD;
        if (r < 93) return cbmq_pkg::OP_INSERT;
        return OP_UNUSED_FIRST + 3'($urandom_range(2));
    endfunction

    // clear (always when big, else most times), fill some chains, then walk and query them
    task automatic run_episode(bit big);
        int         n_ins;
        int         n_q;
        logic [6:0] base;
        bit         narrow;
        base   = 7'($urandom_range(127));
        narrow = ($urandom_range(9) < 7);
        if (big || $urandom_range(9) != 0) issue(rand_cmd(cbmq_pkg::OP_CLEAR, base, narrow));
        n_ins = (big || $urandom_range(11) == 0) ? $urandom_range(280, 300) : $urandom_range(24);
        for (int k = 0; k < n_ins; k++) begin
            if ($urandom_range(99) < 15) issue(rand_cmd(pick_query_op(), base, narrow));
            issue(rand_cmd(cbmq_pkg::OP_INSERT, base, narrow));
        end
        n_q = $urandom_range(4, 30);
        for (int k = 0; k < n_q; k++) issue(rand_cmd(pick_query_op(), base, narrow));
    endtask

    t_row directed_plan [26] = '{
        '{'{cbmq_pkg::OP_GET_NEXT, 7'd0, cbmq_pkg::DIR_NONE, 4'd0,
            cbmq_pkg::GRP_SINGLE, 4'd15}, 1'b1,
          '{cbmq_pkg::ST_NONE, 1'b0, 7'd0, 3'd0, 4'd0}},
        '{'{cbmq_pkg::OP_HAS_FIELD, 7'd0, cbmq_pkg::DIR_NONE, 4'd0,
            cbmq_pkg::GRP_SINGLE, 4'd0}, 1'b1,
          '{cbmq_pkg::ST_NONE, 1'b0, 7'd0, 3'd0, 4'd0}},
        '{'{cbmq_pkg::OP_FIND, 7'd0, cbmq_pkg::DIR_NONE, 4'd13,
            cbmq_pkg::GRP_ALL, 4'd0}, 1'b1,
          '{cbmq_pkg::ST_NONE, 1'b0, 7'd0, 3'd0, 4'd0}},
        '{'{cbmq_pkg::OP_CLEAR, 7'd0, cbmq_pkg::DIR_NONE, 4'd0,
            cbmq_pkg::GRP_SINGLE, 4'd0}, 1'b1,
          '{cbmq_pkg::ST_OK, 1'b0, 7'd0, 3'd0, 4'd0}},
        '{'{cbmq_pkg::OP_INSERT, 7'd127, 3'd6, 4'd12,
            cbmq_pkg::GRP_ALL, 4'd15}, 1'b1,
          '{cbmq_pkg::ST_OK, 1'b0, 7'd0, 3'd0, 4'd0}},
        '{'{cbmq_pkg::OP_INSERT, 7'd0, 3'd1, 4'd0,
            cbmq_pkg::GRP_SINGLE, 4'd0}, 1'b1,
          '{cbmq_pkg::ST_OK, 1'b0, 7'd0, 3'd0, 4'd0}},
        '{'{cbmq_pkg::OP_INSERT, 7'd33, 3'd5, 4'd13,
            cbmq_pkg::GRP_PAIR, 4'd0}, 1'b1,
          '{cbmq_pkg::ST_BAD, 1'b0, 7'd0, 3'd0, 4'd0}},
        '{'{cbmq_pkg::OP_INSERT, 7'd33, 3'd5, 4'd15,
            cbmq_pkg::GRP_PAIR, 4'd0}, 1'b1,
          '{cbmq_pkg::ST_BAD, 1'b0, 7'd0, 3'd0, 4'd0}},
        '{'{cbmq_pkg::OP_INSERT, 7'd5, 3'd3, 4'd7,
            cbmq_pkg::GRP_SINGLE, 4'd0}, 1'b1,
          '{cbmq_pkg::ST_OK, 1'b0, 7'd0, 3'd0, 4'd0}},
        '{'{cbmq_pkg::OP_INSERT, 7'd5, 3'd4, 4'd9,
            cbmq_pkg::GRP_SINGLE, 4'd0}, 1'b1,
          '{cbmq_pkg::ST_OK, 1'b0, 7'd0, 3'd0, 4'd0}},
        '{'{cbmq_pkg::OP_INSERT, 7'd5, 3'd2, 4'd0,
            cbmq_pkg::GRP_SINGLE, 4'd0}, 1'b1,
          '{cbmq_pkg::ST_OK, 1'b0, 7'd0, 3'd0, 4'd0}},
        '{'{cbmq_pkg::OP_INSERT, 7'd64, 3'd2, 4'd0,
            cbmq_pkg::GRP_SINGLE, 4'd0}, 1'b1,
          '{cbmq_pkg::ST_OK, 1'b0, 7'd0, 3'd0, 4'd0}},
        '{'{cbmq_pkg::OP_HAS_FIELD, 7'd127, cbmq_pkg::DIR_NONE, 4'd0,
            cbmq_pkg::GRP_SINGLE, 4'd0}, 1'b1,
          '{cbmq_pkg::ST_OK, 1'b1, 7'd127, 3'd0, 4'd0}},
        '{'{cbmq_pkg::OP_HAS_FIELD, 7'd100, cbmq_pkg::DIR_NONE, 4'd0,
            cbmq_pkg::GRP_SINGLE, 4'd0}, 1'b1,
          '{cbmq_pkg::ST_NONE, 1'b0, 7'd0, 3'd0, 4'd0}},
        // partial matches through the side-move groups
        '{'{cbmq_pkg::OP_FIND, 7'd5, cbmq_pkg::DIR_NONE, 4'd13,
            cbmq_pkg::GRP_TRIPLE, 4'd0}, 1'b0, '0},
        '{'{cbmq_pkg::OP_FIND, 7'd5, cbmq_pkg::DIR_NONE, 4'd13,
            cbmq_pkg::GRP_PAIR, 4'd0}, 1'b0, '0},
        '{'{cbmq_pkg::OP_FIND, 7'd5, cbmq_pkg::DIR_NONE, 4'd13,
            cbmq_pkg::GRP_SINGLE, 4'd0}, 1'b0, '0},
        '{'{cbmq_pkg::OP_FIND, 7'd5, 3'd2, 4'd0,
            cbmq_pkg::GRP_PAIR, 4'd0}, 1'b0, '0},
        '{'{cbmq_pkg::OP_FIND, 7'd5, 3'd6, 4'd13,
            cbmq_pkg::GRP_ALL, 4'd0}, 1'b1,
          '{cbmq_pkg::ST_NONE, 1'b0, 7'd0, 3'd0, 4'd0}},
        '{'{cbmq_pkg::OP_GET_NEXT, 7'd0, cbmq_pkg::DIR_NONE, 4'd0,
            cbmq_pkg::GRP_SINGLE, 4'd0}, 1'b1,
          '{cbmq_pkg::ST_OK, 1'b1, 7'd0, 3'd1, 4'd0}},
        '{'{cbmq_pkg::OP_GET_NEXT, 7'd0, cbmq_pkg::DIR_NONE, 4'd0,
            cbmq_pkg::GRP_SINGLE, 4'd0}, 1'b0, '0},
        // last record of class zero
        '{'{cbmq_pkg::OP_GET_NEXT, 7'd0, cbmq_pkg::DIR_NONE, 4'd0,
            cbmq_pkg::GRP_SINGLE, 4'd0}, 1'b1,
          '{cbmq_pkg::ST_OK, 1'b1, 7'd64, 3'd2, 4'd0}},
        '{'{cbmq_pkg::OP_GET_NEXT, 7'd0, cbmq_pkg::DIR_NONE, 4'd0,
            cbmq_pkg::GRP_SINGLE, 4'd15}, 1'b0, '0},
        // refused past the limit, but the cursor lands on the next class
        '{'{cbmq_pkg::OP_GET_NEXT, 7'd0, cbmq_pkg::DIR_NONE, 4'd0,
            cbmq_pkg::GRP_SINGLE, 4'd8}, 1'b0, '0},
        '{'{cbmq_pkg::OP_GET_NEXT, 7'd0, cbmq_pkg::DIR_NONE, 4'd0,
            cbmq_pkg::GRP_SINGLE, 4'd0}, 1'b0, '0},
        '{'{OP_UNUSED_LAST, 7'd127, 3'd6, 4'd15,
            cbmq_pkg::GRP_ALL, 4'd15}, 1'b1,
          '{cbmq_pkg::ST_OK, 1'b0, 7'd0, 3'd0, 4'd0}}
    };

    initial begin
        int target;
        clear_queue();
        cfg = '{cbmq_pkg::RST_NONE, cbmq_pkg::RST_S3_LEFT, cbmq_pkg::RST_S3_RIGHT,
                cbmq_pkg::RST_S2_LEFT, cbmq_pkg::RST_S2_RIGHT};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < $size(directed_plan); k++)
            issue(directed_plan[k].c, directed_plan[k].chk, directed_plan[k].r);

        for (int seg = 0; seg < 6; seg++) begin
            pause_until_drained();
            configure(settings_for(seg));
            idle_pct = (seg < 2) ? 15 : (seg < 4) ? 56 : 0;
            target   = items_sent + SEG_ITEMS;
            // one full-store episode is forced in segment 4, where the sender never idles
            run_episode(seg == 4);
            while (items_sent < target) begin
                run_episode(1'b0);
                if ($urandom_range(19) == 0) pause_until_drained();
            end
        end

        pause_until_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: class_bucketed_move_queue.f
hdl/cbmq_pkg.sv
hdl/cbmq_ram.sv
hdl/cbmq_match.sv
hdl/class_bucketed_move_queue.sv
tb/tb_class_bucketed_move_queue.sv
